FILE: hw/rtl/lfp_pkg.sv
// Shared constants, types and codes of the lidar frame parser.
package lfp_pkg;

    localparam int PAYLOAD_BYTES = 6;
    localparam int COUNT_W       = $clog2(PAYLOAD_BYTES + 1);
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CHECKSUM_SEED = CFG_INDEX_W'(1);

    localparam logic [7:0] SYNC_BYTE_RESET     = 8'd89;
    localparam logic [7:0] CHECKSUM_SEED_RESET = 8'd178;

    typedef enum logic [1:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_DATA
    } phase_t;

    // Per-beat events from the frame controller
    typedef struct packed {
        logic shift;    // payload byte accepted: advance the cell chain
        logic emit;     // checksum byte accepted: load the result register
        logic ok;       // checksum matched on this beat
        logic at_check; // next accepted byte is the checksum byte
    } lfp_evt_t;

endpackage

FILE: hw/rtl/lfp_cell.sv
// One byte cell of the payload chain: load from the left neighbor on shift.
module lfp_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] byte_in,
    output logic [7:0] byte_out
);

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= byte_in;
        end
    end

    assign byte_out = data_reg;

endmodule

FILE: hw/rtl/lfp_ctrl.sv
// Frame controller: sync hunt, payload byte count and running checksum.
module lfp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    input  logic [7:0]      sync_byte,
    input  logic [7:0]      checksum_seed,
    output lfp_pkg::lfp_evt_t evt
);

    lfp_pkg::phase_t                 phase_reg, phase_next;
    logic [lfp_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [7:0]                      sum_reg, sum_next;
    logic                            sync_hit;
    logic                            count_full;

    assign sync_hit   = (rx_byte == sync_byte);
    assign count_full = (count_reg == lfp_pkg::COUNT_W'(lfp_pkg::PAYLOAD_BYTES));

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            lfp_pkg::PH_SYNC1:
            begin
                if (accept && sync_hit)
                begin
                    phase_next = lfp_pkg::PH_SYNC2;
                end
            end
            lfp_pkg::PH_SYNC2:
            begin
                if (accept)
                begin
                    phase_next = sync_hit ? lfp_pkg::PH_DATA : lfp_pkg::PH_SYNC1;
                end
            end
            lfp_pkg::PH_DATA:
            begin
                if (accept && count_full)
                begin
                    phase_next = lfp_pkg::PH_SYNC1;
                end
            end
            default:
            begin
                phase_next = lfp_pkg::PH_SYNC1;
            end
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        evt.shift    = 1'b0;
        evt.emit     = 1'b0;
        evt.ok       = (sum_reg == rx_byte);
        evt.at_check = 1'b0;
        case (phase_reg)
            lfp_pkg::PH_SYNC2:
            begin
                if (accept && sync_hit)
                begin
                    count_next = '0;
                    sum_next   = checksum_seed;
                end
            end
            lfp_pkg::PH_DATA:
            begin
                evt.at_check = count_full;
                if (accept)
                begin
                    if (count_full)
                    begin
                        evt.emit = 1'b1;
                    end
                    else
                    begin
                        evt.shift  = 1'b1;
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + rx_byte;
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lfp_pkg::PH_SYNC1;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

FILE: hw/rtl/lidar_frame_parser.sv
// Top level of the lidar frame parser: controller, payload cell chain, result register.
// A result beat becomes valid in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle; only the checksum byte waits, and only while an
//   earlier result still sits stalled in the output register.
// Reset: rst_n clears the hunt state, count, sum, output valid and restores the
//   registers to sync_byte 89 and checksum_seed 178. Payload cells are not reset.
module lidar_frame_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    // byte input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [15:0]                     distance,
    output logic [15:0]                     strength,
    output logic [7:0]                      integration_time,
    output logic                            checksum_ok,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);

    localparam int N = lfp_pkg::PAYLOAD_BYTES;

    logic [7:0]        sync_byte_reg;
    logic [7:0]        seed_reg;
    logic              in_accept;
    logic              out_take;
    lfp_pkg::lfp_evt_t evt;
    logic [7:0]        cell_byte [N];

    logic              out_valid_reg, out_valid_next;
    logic [15:0]       distance_reg;
    logic [15:0]       strength_reg;
    logic [7:0]        itime_reg;
    logic              ok_reg;

    // Configuration writes land at once; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= lfp_pkg::SYNC_BYTE_RESET;
            seed_reg      <= lfp_pkg::CHECKSUM_SEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lfp_pkg::REG_SYNC_BYTE:     sync_byte_reg <= cfg_data;
                lfp_pkg::REG_CHECKSUM_SEED: seed_reg      <= cfg_data;
                default:                    sync_byte_reg <= sync_byte_reg;
            endcase
        end
    end

    // Hold only the checksum byte while the previous result is still stalled;
    // every other byte passes straight through.
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = evt.at_check && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    lfp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .rx_byte       (rx_byte),
        .sync_byte     (sync_byte_reg),
        .checksum_seed (seed_reg),
        .evt           (evt)
    );

    // Payload chain: each payload beat enters cell 0 and every cell hands its
    // byte to the next. After a full payload, cell N-1 holds payload byte 0.
    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                lfp_cell u_cell (
                    .clk      (clk),
                    .shift    (evt.shift),
                    .byte_in  (rx_byte),
                    .byte_out (cell_byte[k])
                );
            end
            else
            begin : g_body
                lfp_cell u_cell (
                    .clk      (clk),
                    .shift    (evt.shift),
                    .byte_in  (cell_byte[k-1]),
                    .byte_out (cell_byte[k])
                );
            end
        end
    endgenerate

    // Result register: load on the checksum beat, drop valid once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (evt.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.emit)
        begin
            ok_reg <= evt.ok;
            if (evt.ok)
            begin
                distance_reg <= {cell_byte[N-2], cell_byte[N-1]};
                strength_reg <= {cell_byte[N-4], cell_byte[N-3]};
                itime_reg    <= cell_byte[N-5];
            end
            else
            begin
                distance_reg <= '0;
                strength_reg <= '0;
                itime_reg    <= '0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign distance         = distance_reg;
    assign strength         = strength_reg;
    assign integration_time = itime_reg;
    assign checksum_ok      = ok_reg;

endmodule

FILE: hw/rtl/lfp_checker.sv
// Port-level checker for the lidar frame parser, bound to the top level.
module lfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] distance,
    input logic [15:0] strength,
    input logic [7:0]  integration_time,
    input logic        checksum_ok
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance) && $stable(checksum_ok))
        else $error("stalled result beat changed");

    // A failed checksum carries all-zero fields.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !checksum_ok |->
            distance == 16'd0 && strength == 16'd0 && integration_time == 8'd0)
        else $error("checksum error beat with nonzero fields");

    // A new result beat follows an accepted byte.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result beat without an accepted byte");

    // Input holds off only while a result is stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

endmodule

bind lidar_frame_parser lfp_checker u_lfp_checker (.*);

FILE: sim/lidar_frame_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the lidar frame parser: byte stimulus, frame predictor, result checks.

typedef struct packed {
    logic [15:0] distance;
    logic [15:0] strength;
    logic [7:0]  integration_time;
    logic        checksum_ok;
} reading_t;

// Frame predictor plus the queue of readings it expects from the block.
class frame_scoreboard;
    logic [7:0]                      sync_value;
    logic [7:0]                      seed_value;
    lfp_pkg::phase_t                 phase;
    logic [7:0]                      payload [lfp_pkg::PAYLOAD_BYTES];
    logic [lfp_pkg::COUNT_W-1:0]     stored;
    logic [7:0]                      sum;
    reading_t                        expected_readings [$];
    int unsigned                     mismatches;

    function new();
        sync_value = lfp_pkg::SYNC_BYTE_RESET;
        seed_value = lfp_pkg::CHECKSUM_SEED_RESET;
        phase      = lfp_pkg::PH_SYNC1;
        stored     = '0;
        sum        = '0;
        mismatches = 0;
        foreach (payload[i])
            payload[i] = '0;
    endfunction

    // Mirror a register write; unknown indexes are dropped.
    function void write_reg(logic [lfp_pkg::CFG_INDEX_W-1:0] index, logic [7:0] data);
        case (index)
            lfp_pkg::REG_SYNC_BYTE:     sync_value = data;
            lfp_pkg::REG_CHECKSUM_SEED: seed_value = data;
            default: ;
        endcase
    endfunction

    // Advance the frame hunt by one accepted byte beat.
    function void note_byte(logic [7:0] b);
        reading_t r;
        r = '0;
        case (phase)
            lfp_pkg::PH_SYNC1:
                if (b == sync_value)
                    phase = lfp_pkg::PH_SYNC2;
            lfp_pkg::PH_SYNC2:
                if (b == sync_value)
                begin
                    stored = '0;
                    sum    = seed_value;
                    phase  = lfp_pkg::PH_DATA;
                end
                else
                    phase = lfp_pkg::PH_SYNC1;
            lfp_pkg::PH_DATA:
                if (stored < lfp_pkg::PAYLOAD_BYTES)
                begin
                    payload[stored] = b;
                    sum    = sum + b;
                    stored = stored + 1'b1;
                end
                else
                begin
                    phase = lfp_pkg::PH_SYNC1;
                    if (sum == b)
                    begin
                        r.distance         = {payload[1], payload[0]};
                        r.strength         = {payload[3], payload[2]};
                        r.integration_time = payload[4];
                        r.checksum_ok      = 1'b1;
                    end
                    expected_readings.push_back(r);
                end
            default:
                phase = lfp_pkg::PH_SYNC1;
        endcase
    endfunction

    // Compare one result beat against the oldest expected reading.
    function void check_reading(reading_t got);
        reading_t want;
        if (expected_readings.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected reading: dist %0d str %0d int %0d ok %0b",
                         got.distance, got.strength, got.integration_time, got.checksum_ok);
            return;
        end
        want = expected_readings.pop_front();
        if (got.distance !== want.distance || got.strength !== want.strength ||
            got.integration_time !== want.integration_time ||
            got.checksum_ok !== want.checksum_ok)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp d %0d s %0d i %0d ok %0b, got d %0d s %0d i %0d ok %0b",
                         want.distance, want.strength, want.integration_time, want.checksum_ok,
                         got.distance, got.strength, got.integration_time, got.checksum_ok);
        end
    endfunction

    function int unsigned pending();
        return expected_readings.size();
    endfunction
endclass

module lidar_frame_parser_tb;

    // Spare register indexes: the block must ignore writes to them.
    localparam logic [lfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = lfp_pkg::CFG_INDEX_W'(2);
    localparam logic [lfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = lfp_pkg::CFG_INDEX_W'(3);

    localparam int unsigned MAX_WAIT       = 13;
    localparam int unsigned SETTLE_CYCLES  = 4;     // result shows in the cycle after its checksum
    localparam int unsigned RANDOM_BEATS   = 2000;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      rx_byte;
    logic                            out_valid;
    logic                            out_stall;
    logic [15:0]                     distance;
    logic [15:0]                     strength;
    logic [7:0]                      integration_time;
    logic                            checksum_ok;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lfp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]                      cfg_data;

    frame_scoreboard sb = new();

    bit          in_quiet;      // sender runs back to back while set
    bit          out_quiet;     // receiver never stalls while set
    int unsigned useful_beats;  // byte beats the parser did not simply ignore
    int unsigned quiet_cycles;

    lidar_frame_parser DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .distance         (distance),
        .strength         (strength),
        .integration_time (integration_time),
        .checksum_ok      (checksum_ok),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Favor the register extremes, otherwise any value.
    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] non_sync_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == sb.sync_value);
        return b;
    endfunction

    // Drive one byte beat: idle for a drawn gap, then hold valid until the block takes it.
    // Valid stays high on exit so a gapless next beat never drops it.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_wait(in_quiet);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (sb.phase != lfp_pkg::PH_SYNC1 || b == sb.sync_value)
            useful_beats++;
        sb.note_byte(b);
    endtask

    // Drop valid and let every expected reading drain before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold one register write until the block takes it; end_writes drops valid afterwards.
    task automatic write_reg(input logic [lfp_pkg::CFG_INDEX_W-1:0] index, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(index, data);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    // Send a complete frame with random payload; optionally retune the registers
    // right after the header, while the frame is still open.
    task automatic send_frame(input bit good_sum, input bit retune_mid);
        logic [7:0] data;
        logic [7:0] check;
        send_byte(sb.sync_value);
        send_byte(sb.sync_value);
        check = sb.seed_value;      // the seed is latched with the second header byte
        if (retune_mid)
        begin
            settle();
            write_reg(lfp_pkg::REG_SYNC_BYTE, pick_reg_value());
            write_reg(lfp_pkg::REG_CHECKSUM_SEED, pick_reg_value());
            end_writes();
        end
        for (int i = 0; i < lfp_pkg::PAYLOAD_BYTES; i++)
        begin
            data  = 8'($urandom);
            check = check + data;
            send_byte(data);
        end
        send_byte(good_sum ? check : check ^ 8'($urandom_range(1, 255)));
    endtask

    // Receiver: stall for a drawn number of cycles, then take the next result beat.
    initial
    begin : receiver
        int unsigned hold;
        out_stall <= 1'b0;
        forever
        begin
            hold = draw_wait(out_quiet);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Check every accepted result beat.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reading('{distance, strength, integration_time, checksum_ok});
    end

    // Watchdog: end the run if no channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("lidar_frame_parser_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] d;
        int unsigned k;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        rx_byte      <= 8'h00;
        cfg_valid    <= 1'b0;
        cfg_index    <= lfp_pkg::REG_SYNC_BYTE;
        cfg_data     <= 8'h00;
        in_quiet     = 1'b0;
        out_quiet    = 1'b0;
        useful_beats = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: run on the reset register values first.
        // Noise, then a sync followed by a non-sync second byte: back to hunting.
        send_byte(8'h00);
        send_byte(sb.sync_value);
        send_byte(8'hFF);
        // Good frame with extreme payload bytes and the sync value inside the payload.
        d = sb.seed_value;
        send_byte(sb.sync_value);
        send_byte(sb.sync_value);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(sb.sync_value);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);   // last payload byte: summed but never reported
        d = d + 8'hFF + 8'h00 + sb.sync_value + 8'hFF + 8'h00 + 8'hA5;
        send_byte(d);
        // Header, then change the seed and poke a spare index mid-frame; the latched
        // seed still governs this frame, whose checksum is wrong.
        send_byte(sb.sync_value);
        send_byte(sb.sync_value);
        settle();
        write_reg(lfp_pkg::REG_CHECKSUM_SEED, 8'h00);
        write_reg(REG_SPARE_A, 8'hFF);
        end_writes();
        for (int i = 0; i < lfp_pkg::PAYLOAD_BYTES; i++)
            send_byte(8'($urandom));
        send_byte(sb.sum ^ 8'h01);

        // Register extremes in their own short phases.
        settle();
        write_reg(lfp_pkg::REG_SYNC_BYTE, 8'h00);
        write_reg(lfp_pkg::REG_CHECKSUM_SEED, 8'hFF);
        write_reg(REG_SPARE_B, 8'h00);
        end_writes();
        send_frame(1'b1, 1'b0);
        settle();
        write_reg(lfp_pkg::REG_SYNC_BYTE, 8'hFF);
        write_reg(lfp_pkg::REG_CHECKSUM_SEED, 8'h00);
        end_writes();
        send_frame(1'b1, 1'b0);

        // Random phases: mostly well-formed frames with random content, some with a bad checksum,
        // noise, broken headers, truncated frames and retunes inside an open frame.
        useful_beats = 0;
        while (useful_beats < RANDOM_BEATS)
        begin
            settle();
            if ($urandom_range(0, 3) != 0)
                write_reg(lfp_pkg::REG_SYNC_BYTE, pick_reg_value());
            if ($urandom_range(0, 3) != 0)
                write_reg(lfp_pkg::REG_CHECKSUM_SEED, pick_reg_value());
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
            end_writes();
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 16))
            begin
                case ($urandom_range(0, 11))
                    0: send_byte(8'($urandom));
                    1:
                    begin
                        send_byte(sb.sync_value);
                        send_byte(non_sync_byte());
                    end
                    2:
                    begin
                        // truncate: the next bytes land inside this frame
                        send_byte(sb.sync_value);
                        send_byte(sb.sync_value);
                        k = $urandom_range(0, lfp_pkg::PAYLOAD_BYTES - 1);
                        repeat (k) send_byte(8'($urandom));
                    end
                    3:  send_frame($urandom_range(0, 3) != 0, 1'b1);
                    4:  send_frame(1'b0, 1'b0);
                    default: send_frame(1'b1, 1'b0);
                endcase
            end
        end

        // Drain: wait out every expected reading, then watch on for strays.
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("lidar_frame_parser_tb: clean");
        else
            $display("lidar_frame_parser_tb: errors");
        $finish;
    end
endmodule
